FILE: rtl/psfc_pkg.sv
package psfc_pkg;

    // sample width codes, shared by the source and destination sides
    localparam logic [2:0] WIDTH_8   = 3'd0;
    localparam logic [2:0] WIDTH_16  = 3'd1;
    localparam logic [2:0] WIDTH_24  = 3'd2;
    localparam logic [2:0] WIDTH_32  = 3'd3;
    localparam logic [2:0] WIDTH_P24 = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_SRC_WIDTH_CODE = 3'd0;
    localparam logic [2:0] REG_SRC_UNSIGNED   = 3'd1;
    localparam logic [2:0] REG_SRC_BIG_ENDIAN = 3'd2;
    localparam logic [2:0] REG_DST_WIDTH_CODE = 3'd3;
    localparam logic [2:0] REG_DST_UNSIGNED   = 3'd4;
    localparam logic [2:0] REG_DST_BIG_ENDIAN = 3'd5;

    // sign bit masks at each width
    localparam logic [31:0] SIGN_8  = 32'h0000_0080;
    localparam logic [31:0] SIGN_16 = 32'h0000_8000;
    localparam logic [31:0] SIGN_24 = 32'h0080_0000;
    localparam logic [31:0] SIGN_32 = 32'h8000_0000;

    // format settings as seen by the conversion datapath
    typedef struct packed {
        logic [2:0] src_width_code;
        logic       src_unsigned;
        logic       src_big_endian;
        logic [2:0] dst_width_code;
        logic       dst_unsigned;
        logic       dst_big_endian;
    } psfc_cfg_t;

endpackage

FILE: rtl/psfc_convert.sv
module psfc_convert
    import psfc_pkg::*;
(
    input  psfc_cfg_t   cfg,
    input  logic [31:0] sample_in,
    output logic [31:0] sample_out
);

    // effective bit width after unpacking
    typedef enum logic [1:0] {
        EFF_8,
        EFF_16,
        EFF_24,
        EFF_32
    } eff_width_t;

    function automatic eff_width_t eff_of(input logic [2:0] code);
        eff_width_t e;
        case (code)
            WIDTH_8:  e = EFF_8;
            WIDTH_16: e = EFF_16;
            WIDTH_32: e = EFF_32;
            default:  e = EFF_24;
        endcase
        return e;
    endfunction

    function automatic logic [31:0] swap4(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    eff_width_t  src_eff;
    eff_width_t  dst_eff;
    logic        bad_code;
    logic [31:0] unpacked;
    logic [31:0] toggled;
    logic [31:0] aligned;
    logic [31:0] resized;
    logic [31:0] packed_out;

    assign src_eff  = eff_of(cfg.src_width_code);
    assign dst_eff  = eff_of(cfg.dst_width_code);
    assign bad_code = (cfg.src_width_code > WIDTH_P24) || (cfg.dst_width_code > WIDTH_P24);

    // unpack by source byte order
    always_comb begin
        logic [23:0] b24;
        b24 = cfg.src_big_endian ? {sample_in[7:0], sample_in[15:8], sample_in[23:16]}
                                 : sample_in[23:0];
        case (cfg.src_width_code)
            WIDTH_8: begin
                unpacked = {24'd0, sample_in[7:0]};
            end
            WIDTH_16: begin
                unpacked = cfg.src_big_endian ? {16'd0, sample_in[7:0], sample_in[15:8]}
                                              : {16'd0, sample_in[15:0]};
            end
            WIDTH_P24: begin
                unpacked = {((!cfg.src_unsigned && b24[23]) ? 8'hFF : 8'h00), b24};
            end
            default: begin
                unpacked = cfg.src_big_endian ? swap4(sample_in) : sample_in;
            end
        endcase
    end

    // sign toggle at the source width
    always_comb begin
        logic t;
        t = ~unpacked[23];
        toggled = unpacked;
        if (cfg.src_unsigned != cfg.dst_unsigned) begin
            case (src_eff)
                EFF_8:  toggled = unpacked ^ SIGN_8;
                EFF_16: toggled = unpacked ^ SIGN_16;
                EFF_32: toggled = unpacked ^ SIGN_32;
                default: begin
                    if (!cfg.src_unsigned) begin
                        toggled = unpacked + SIGN_24;
                    end else begin
                        toggled = {{8{t}}, t, unpacked[22:0]};
                    end
                end
            endcase
        end
    end

    // left-align at the source width
    always_comb begin
        case (src_eff)
            EFF_8:   aligned = {toggled[7:0], 24'd0};
            EFF_16:  aligned = {toggled[15:0], 16'd0};
            EFF_24:  aligned = {toggled[23:0], 8'd0};
            default: aligned = toggled;
        endcase
    end

    // width change to the destination
    always_comb begin
        resized = toggled;
        if (src_eff != dst_eff) begin
            case (dst_eff)
                EFF_8:  resized = {24'd0, aligned[31:24]};
                EFF_16: resized = {16'd0, aligned[31:16]};
                EFF_32: resized = aligned;
                default: begin
                    resized = {((!cfg.dst_unsigned && aligned[31]) ? 8'hFF : 8'h00),
                               aligned[31:8]};
                end
            endcase
        end
    end

    // repack by destination byte order
    always_comb begin
        case (cfg.dst_width_code)
            WIDTH_8: begin
                packed_out = {24'd0, resized[7:0]};
            end
            WIDTH_16: begin
                packed_out = cfg.dst_big_endian ? {16'd0, resized[7:0], resized[15:8]}
                                                : {16'd0, resized[15:0]};
            end
            WIDTH_P24: begin
                packed_out = cfg.dst_big_endian
                           ? {8'd0, resized[7:0], resized[15:8], resized[23:16]}
                           : {8'd0, resized[23:0]};
            end
            default: begin
                packed_out = cfg.dst_big_endian ? swap4(resized) : resized;
            end
        endcase
    end

    assign sample_out = bad_code ? 32'd0 : packed_out;

endmodule

FILE: rtl/pcm_sample_format_converter_unit.sv
// PCM integer sample format converter: each transaction on the s_ side carries one
// sample in its source container (8, 16, 24 in 32, 32 or packed 3-byte 24 bits,
// signed or unsigned, little or big endian, first stored byte in bits 7:0) and yields
// exactly one transaction on the m_ side with the sample in the destination format;
// a width code above 4 on either side gives zero. The block takes one sample per
// clock: an input register feeds a single combinational conversion into the output
// register, whose valid flag drives m_valid, and stalls on m_ready propagate back to
// s_ready only when both registers hold data. Format registers are written through
// cfg_we/cfg_addr/cfg_wdata and must only change while the block is empty.
module pcm_sample_format_converter_unit
    import psfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [2:0]  cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_sample_in,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_sample_out
);

    psfc_cfg_t   cfg_reg;
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [31:0] in_sample_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_sample_reg;
    logic [31:0] conv_sample;
    logic        in_accept;
    logic        out_load;

    // format registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_width_code <= WIDTH_16;
            cfg_reg.src_unsigned   <= 1'b0;
            cfg_reg.src_big_endian <= 1'b0;
            cfg_reg.dst_width_code <= WIDTH_16;
            cfg_reg.dst_unsigned   <= 1'b0;
            cfg_reg.dst_big_endian <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_SRC_WIDTH_CODE: cfg_reg.src_width_code <= cfg_wdata;
                REG_SRC_UNSIGNED:   cfg_reg.src_unsigned   <= cfg_wdata[0];
                REG_SRC_BIG_ENDIAN: cfg_reg.src_big_endian <= cfg_wdata[0];
                REG_DST_WIDTH_CODE: cfg_reg.dst_width_code <= cfg_wdata;
                REG_DST_UNSIGNED:   cfg_reg.dst_unsigned   <= cfg_wdata[0];
                REG_DST_BIG_ENDIAN: cfg_reg.dst_big_endian <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // pipeline handshake
    assign out_load  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || out_load;
    assign in_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_accept) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_sample_reg <= s_sample_in;
        end
        if (out_load) begin
            out_sample_reg <= conv_sample;
        end
    end

    psfc_convert u_convert (
        .cfg        (cfg_reg),
        .sample_in  (in_sample_reg),
        .sample_out (conv_sample)
    );

    assign m_valid      = out_valid_reg;
    assign m_sample_out = out_sample_reg;

`ifndef SYNTHESIS
    // an empty output stage always lets a new transaction in
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("s_ready low with empty output stage");

    // a held input stage keeps its sample
    a_in_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_load) |=> (in_valid_reg && $stable(in_sample_reg)))
        else $error("input stage lost or changed a waiting sample");

    // invalid width codes give a zero result
    a_bad_code_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && ((cfg_reg.src_width_code > WIDTH_P24) ||
                      (cfg_reg.dst_width_code > WIDTH_P24))) |=> (m_sample_out == 32'd0))
        else $error("nonzero result for invalid width code");

    // an 8-bit destination never sets bits above the container
    a_dst8_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (cfg_reg.dst_width_code == WIDTH_8)) |=> (m_sample_out[31:8] == 24'd0))
        else $error("8-bit result has upper bits set");

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");
`endif

endmodule
